/* rtl/core/sstf_disk_request_scheduler_macros.svh */
// Assertion helpers for the seek scheduler.
// Checks compile out when SYNTHESIS is defined.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
`define SSTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sstf: same-cycle check failed");
`define SSTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sstf: next-cycle check failed");
`else
`define SSTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/sstf_pkg.sv */
`default_nettype none

package sstf_pkg;

    // fixed field widths
    localparam int REQ_W = 16;
    localparam int SUM_W = 22;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

`default_nettype wire

/* rtl/core/sstf_req_if.sv */
`default_nettype none

interface sstf_req_if import sstf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] request_cylinder;
    logic             batch_end;

    modport source (output valid, output request_cylinder, output batch_end, input ready);
    modport sink   (input valid, input request_cylinder, input batch_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/sstf_res_if.sv */
`default_nettype none

interface sstf_res_if import sstf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] served_cylinder;
    logic [REQ_W-1:0] seek_distance;
    logic [SUM_W-1:0] total_seek;
    logic             run_last;
    logic             overflowed;

    modport source (output valid, output served_cylinder, output seek_distance,
                    output total_seek, output run_last, output overflowed, input ready);
    modport sink   (input valid, input served_cylinder, input seek_distance,
                    input total_seek, input run_last, input overflowed, output ready);
endinterface

`default_nettype wire

/* rtl/core/sstf_disk_request_scheduler.sv */
// Shortest-seek-first disk request scheduler.
// i_req (valid/ready): one cylinder request per word. While idle the block takes
//   one word per cycle into a request store of MAX_REQUESTS entries. Words past
//   capacity are dropped and every result of that batch shows overflowed.
// The word with batch_end set is stored like the others and starts the drain;
//   i_req.ready stays low until the drain is over.
// i_cfg_wr_en/i_cfg_wr_data: start head cylinder, sampled when a drain starts.
// o_res (valid/ready): one word per served request, nearest unserved request
//   first, earliest loaded wins a tie; run_last marks the final one.
// Picks: each pick walks the store through its single read port, one entry a
//   cycle, then commits the best entry from the S_FINISH state.
// The result sits in an output register; a stalled receiver holds the drain in
//   its commit step until the word is taken. The last word may still wait
//   there while the next batch loads.
// Reset (synchronous, active low) empties the batch, clears the output valid
//   and sets the start head to 0. The store itself is not cleared: only entries
//   loaded in the current batch are ever read.
`default_nettype none
`include "sstf_disk_request_scheduler_macros.svh"

module sstf_disk_request_scheduler
    import sstf_pkg::*;
#(
    parameter int MAX_REQUESTS  = 32,
    parameter int CYLINDER_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_wr_en,
    input  wire  [REQ_W-1:0]   i_cfg_wr_data,
    sstf_req_if.sink           i_req,
    sstf_res_if.source         o_res
);

    // stored cylinder width: requests are cut to CYLINDER_BITS and to the field
    localparam int CW   = (CYLINDER_BITS < REQ_W) ? CYLINDER_BITS : REQ_W;
    localparam int CNTW = $clog2(MAX_REQUESTS + 1);
    localparam int IW   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]              r_state;
    logic [REQ_W-1:0]        r_start_head;
    logic [CW-1:0]           r_mem [MAX_REQUESTS];
    logic [CNTW-1:0]         r_count;
    logic                    r_drop;
    logic [MAX_REQUESTS-1:0] r_served;
    logic [CW-1:0]           r_head;
    logic [SUM_W-1:0]        r_sum;
    logic [IW-1:0]           r_pick;

    // scan pipeline: read issue, then compare against the running best
    logic [IW-1:0]           r_rd_idx;
    logic                    r_rd_go;
    logic [CW-1:0]           r_rd_data;
    logic                    r_cmp_vld;
    logic                    r_cmp_last;
    logic [IW-1:0]           r_cmp_idx;
    logic                    r_have_best;
    logic [IW-1:0]           r_best_idx;
    logic [CW-1:0]           r_best_cyl;
    logic [CW-1:0]           r_best_d;

    // output register
    logic                    r_out_vld;
    logic [REQ_W-1:0]        r_out_cyl;
    logic [REQ_W-1:0]        r_out_dist;
    logic [SUM_W-1:0]        r_out_sum;
    logic                    r_out_last;
    logic                    r_out_ovf;

    logic                    w_in_fire;
    logic                    w_room;
    logic                    w_wr;
    logic                    w_rd_last;
    logic [CW-1:0]           w_diff;
    logic                    w_take;
    logic                    w_out_free;
    logic                    w_commit;
    logic                    w_pick_last;
    logic [SUM_W:0]          w_sum_wide;
    logic [SUM_W-1:0]        w_sum_next;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_fire   = i_req.valid && i_req.ready;
    assign w_room      = (r_count < CNTW'(MAX_REQUESTS));
    assign w_wr        = w_in_fire && w_room;

    assign w_rd_last   = ((CNTW'(r_rd_idx) + 1'b1) == r_count);

    // shared distance / compare unit
    assign w_diff = (r_rd_data >= r_head) ? (r_rd_data - r_head) : (r_head - r_rd_data);
    assign w_take = r_cmp_vld && !r_served[r_cmp_idx]
                    && (!r_have_best || (w_diff < r_best_d));

    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_commit    = (r_state == S_FINISH) && w_out_free;
    assign w_pick_last = ((CNTW'(r_pick) + 1'b1) == r_count);

    // saturating running sum
    assign w_sum_wide = {1'b0, r_sum} + (SUM_W+1)'(r_best_d);
    assign w_sum_next = w_sum_wide[SUM_W] ? SUM_MAX : w_sum_wide[SUM_W-1:0];

    // request store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_count[IW-1:0]] <= i_req.request_cylinder[CW-1:0];
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start_head <= '0;
            r_count      <= '0;
            r_drop       <= 1'b0;
            r_served     <= '0;
            r_head       <= '0;
            r_sum        <= '0;
            r_pick       <= '0;
            r_rd_idx     <= '0;
            r_rd_go      <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_cmp_last   <= 1'b0;
            r_cmp_idx    <= '0;
            r_have_best  <= 1'b0;
            r_best_idx   <= '0;
            r_best_cyl   <= '0;
            r_best_d     <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_head <= i_cfg_wr_data;
            end

            if (r_out_vld && o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        if (w_room) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_req.batch_end) begin
                            r_head      <= r_start_head[CW-1:0];
                            r_sum       <= '0;
                            r_pick      <= '0;
                            r_rd_idx    <= '0;
                            r_rd_go     <= 1'b1;
                            r_have_best <= 1'b0;
                            r_state     <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (r_rd_go) begin
                        r_cmp_vld  <= 1'b1;
                        r_cmp_idx  <= r_rd_idx;
                        r_cmp_last <= w_rd_last;
                        r_rd_idx   <= r_rd_idx + 1'b1;
                        if (w_rd_last) begin
                            r_rd_go <= 1'b0;
                        end
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    // strict less-than keeps the earliest entry on a tie
                    if (w_take) begin
                        r_have_best <= 1'b1;
                        r_best_idx  <= r_cmp_idx;
                        r_best_cyl  <= r_rd_data;
                        r_best_d    <= w_diff;
                    end
                    if (r_cmp_vld && r_cmp_last) begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    if (w_commit) begin
                        r_out_vld <= 1'b1;
                        r_head    <= r_best_cyl;
                        if (w_pick_last) begin
                            r_served <= '0;
                            r_count  <= '0;
                            r_drop   <= 1'b0;
                            r_sum    <= '0;
                            r_pick   <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_served[r_best_idx] <= 1'b1;
                            r_sum       <= w_sum_next;
                            r_pick      <= r_pick + 1'b1;
                            r_rd_idx    <= '0;
                            r_rd_go     <= 1'b1;
                            r_have_best <= 1'b0;
                            r_state     <= S_SCAN;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload, loaded on commit
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_cyl  <= REQ_W'(r_best_cyl);
            r_out_dist <= REQ_W'(r_best_d);
            r_out_sum  <= w_sum_next;
            r_out_last <= w_pick_last;
            r_out_ovf  <= r_drop;
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.served_cylinder = r_out_cyl;
    assign o_res.seek_distance   = r_out_dist;
    assign o_res.total_seek      = r_out_sum;
    assign o_res.run_last        = r_out_last;
    assign o_res.overflowed      = r_out_ovf;

    // fill level never passes capacity
    `SSTF_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNTW'(MAX_REQUESTS))
    // a commit always has a winner that was not yet served
    `SSTF_ASSERT_IMP(a_commit_fresh, i_clk, i_rst_n, w_commit,
                     r_have_best && !r_served[r_best_idx])
    // commit never overwrites a word the receiver has not taken
    `SSTF_ASSERT_IMP(a_out_free, i_clk, i_rst_n, w_commit, !r_out_vld || o_res.ready)
    // final pick empties the batch and reopens the input
    `SSTF_ASSERT_NXT(a_drain_done, i_clk, i_rst_n, w_commit && w_pick_last,
                     (r_state == S_IDLE) && (r_count == '0) && !r_drop
                     && (r_served == '0) && o_res.valid && o_res.run_last)

endmodule

`default_nettype wire
